// ===== rtl/astc_partition_select_defines.svh =====
// ============================================================================
// ASTC partition select assertion macros
// Shared assertion forms for the partition select block.
// ============================================================================
`ifndef ASTC_PARTITION_SELECT_DEFINES_SVH
`define ASTC_PARTITION_SELECT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aps_pkg.sv =====
// ============================================================================
// ASTC partition select package
// Types, constants and helper functions shared by the pipeline modules.
// ============================================================================
package aps_pkg;

    localparam int unsigned SeedW  = 10;
    localparam int unsigned CountW = 3;
    localparam int unsigned CoordW = 4;
    localparam int unsigned IdxW   = 2;
    localparam int unsigned SumW   = 6;
    localparam int unsigned HashW  = 32;

    localparam logic [2:0] ShiftLow  = 3'd4;
    localparam logic [2:0] ShiftMid  = 3'd5;
    localparam logic [2:0] ShiftHigh = 3'd6;

    localparam logic [CountW-1:0] CountMin = 3'd1;
    localparam logic [CountW-1:0] CountMax = 3'd4;

    localparam logic [IdxW-1:0] Part0 = 2'd0;
    localparam logic [IdxW-1:0] Part1 = 2'd1;
    localparam logic [IdxW-1:0] Part2 = 2'd2;
    localparam logic [IdxW-1:0] Part3 = 2'd3;

    typedef struct packed {
        logic [HashW-1:0]    p;
        logic [IdxW-1:0]     cnt_m1;
        logic [2:0]          sh1;
        logic [2:0]          sh2;
        logic [2:0]          sh3;
        logic [CoordW:0]     x;
        logic [CoordW:0]     y;
        logic [CoordW:0]     z;
    } aps_hash_t;

    typedef struct packed {
        logic [SumW-1:0] a;
        logic [SumW-1:0] b;
        logic [SumW-1:0] c;
        logic [SumW-1:0] d;
        logic [IdxW-1:0] cnt_m1;
    } aps_sums_t;

    function automatic logic [7:0] sq_nib(input logic [3:0] v, input logic [2:0] sh);
        logic [7:0] sq;
        sq = {4'b0, v} * {4'b0, v};
        return sq >> sh;
    endfunction

    function automatic logic [SumW-1:0] sq_term(input logic [3:0] v,
                                                input logic [2:0] sh,
                                                input logic [CoordW:0] coord);
        logic [7:0]  s;
        logic [12:0] prod;
        s    = sq_nib(v, sh);
        prod = {5'b0, s} * {8'b0, coord};
        return prod[SumW-1:0];
    endfunction

endpackage

// ===== rtl/astc_partition_select.sv =====
// ============================================================================
// ASTC partition select
// Assigns a texel to its ASTC partition, one request a cycle unless stalled.
// ============================================================================
// Input channel: in_valid with partition_seed, partition_count and the texel
// coordinates; the block raises in_stall when it cannot take the request.
// A request is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid with partition_index; the receiver drives
// out_stall, and a result is taken on an edge with out_valid high and
// out_stall low.
// From the accepting edge to out_valid, the request passes four hash
// registers, the sum register and the output register. Throughput is one
// request per cycle while the output is not stalled, set by the six-stage
// pipeline with one wide add per hash stage and the products in the sum stage.
// Configuration: cfg_we writes cfg_wdata to the small-block mode bit, which
// doubles the coordinates. Write it only while no request is in flight.
// Reset empties the pipeline and clears the mode bit; no clearing pass.
// When the receiver stalls, stages fill up behind the held result and
// in_stall rises only once every stage holds a request.
// ============================================================================
`include "astc_partition_select_defines.svh"

module astc_partition_select (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [aps_pkg::SeedW-1:0]      partition_seed,
    input  logic [aps_pkg::CountW-1:0]     partition_count,
    input  logic [aps_pkg::CoordW-1:0]     texel_x,
    input  logic [aps_pkg::CoordW-1:0]     texel_y,
    input  logic [aps_pkg::CoordW-1:0]     texel_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [aps_pkg::IdxW-1:0]       partition_index
);

    logic               small_block_mode_reg;
    logic               hash_ready;
    logic               hash_valid;
    logic               sums_ready;
    logic               sums_valid;
    logic               sel_ready;
    aps_pkg::aps_hash_t hash;
    aps_pkg::aps_sums_t sums;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            small_block_mode_reg <= 1'b0;
        else if (cfg_we)
            small_block_mode_reg <= cfg_wdata;
    end

    assign in_stall = !hash_ready;

    aps_hash u_hash (
        .clk              (clk),
        .rst_n            (rst_n),
        .small_block_mode (small_block_mode_reg),
        .up_valid         (in_valid),
        .up_ready         (hash_ready),
        .partition_seed   (partition_seed),
        .partition_count  (partition_count),
        .texel_x          (texel_x),
        .texel_y          (texel_y),
        .texel_z          (texel_z),
        .dn_valid         (hash_valid),
        .dn_ready         (sums_ready),
        .hash             (hash)
    );

    aps_sums u_sums (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (hash_valid),
        .up_ready (sums_ready),
        .hash     (hash),
        .dn_valid (sums_valid),
        .dn_ready (sel_ready),
        .sums     (sums)
    );

    aps_select u_select (
        .clk             (clk),
        .rst_n           (rst_n),
        .up_valid        (sums_valid),
        .up_ready        (sel_ready),
        .sums            (sums),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .partition_index (partition_index)
    );

    // With no result waiting at the output, every stage can move, so the
    // input must be open.
    `APS_ASSERT_NOW(a_open_when_drained, clk, rst_n, !out_valid, !in_stall,
                    "Input stalled while the output is empty")

endmodule

// ===== rtl/aps_hash.sv =====
// ============================================================================
// ASTC partition select hash pipeline
// Normalises the request, derives the shift amounts and runs the seed mix
// over four register stages, one wide add per stage.
// ============================================================================
`include "astc_partition_select_defines.svh"

module aps_hash (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           small_block_mode,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic [aps_pkg::SeedW-1:0]      partition_seed,
    input  logic [aps_pkg::CountW-1:0]     partition_count,
    input  logic [aps_pkg::CoordW-1:0]     texel_x,
    input  logic [aps_pkg::CoordW-1:0]     texel_y,
    input  logic [aps_pkg::CoordW-1:0]     texel_z,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output aps_pkg::aps_hash_t             hash
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    aps_pkg::aps_hash_t st1_reg, st2_reg, st3_reg, st4_reg;
    aps_pkg::aps_hash_t st1_next, st2_next, st3_next, st4_next;

    assign rdy4     = !v4_reg || dn_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;
    assign dn_valid = v4_reg;
    assign hash     = st4_reg;

    always_comb
    begin
        logic [aps_pkg::IdxW-1:0]  cm1;
        logic [aps_pkg::HashW-1:0] p;
        logic [2:0]                cnt3_sh;
        logic [2:0]                seed_sh;
        cm1 = '0;
        priority if (partition_count < aps_pkg::CountMin)
            cm1 = '0;
        else if (partition_count > aps_pkg::CountMax)
            cm1 = aps_pkg::IdxW'(aps_pkg::CountMax - aps_pkg::CountMin);
        else
            cm1 = aps_pkg::IdxW'(partition_count - aps_pkg::CountMin);

        p = {{(aps_pkg::HashW - aps_pkg::SeedW - aps_pkg::IdxW){1'b0}}, cm1, partition_seed};
        p = p ^ (p >> 15);
        p = p - (p << 17);

        cnt3_sh = (cm1 == 2'd2) ? aps_pkg::ShiftHigh : aps_pkg::ShiftMid;
        seed_sh = partition_seed[1] ? aps_pkg::ShiftLow : aps_pkg::ShiftMid;

        st1_next        = '0;
        st1_next.p      = p;
        st1_next.cnt_m1 = cm1;
        if (partition_seed[0])
        begin
            st1_next.sh1 = seed_sh;
            st1_next.sh2 = cnt3_sh;
        end
        else
        begin
            st1_next.sh1 = cnt3_sh;
            st1_next.sh2 = seed_sh;
        end
        st1_next.sh3 = partition_seed[4] ? st1_next.sh1 : st1_next.sh2;
        st1_next.x   = small_block_mode ? {texel_x, 1'b0} : {1'b0, texel_x};
        st1_next.y   = small_block_mode ? {texel_y, 1'b0} : {1'b0, texel_y};
        st1_next.z   = small_block_mode ? {texel_z, 1'b0} : {1'b0, texel_z};
    end

    always_comb
    begin
        st2_next   = st1_reg;
        st2_next.p = st1_reg.p + (st1_reg.p << 7);
    end

    always_comb
    begin
        logic [aps_pkg::HashW-1:0] q;
        q          = st2_reg.p + (st2_reg.p << 4);
        st3_next   = st2_reg;
        st3_next.p = q ^ (q >> 5);
    end

    always_comb
    begin
        logic [aps_pkg::HashW-1:0] q;
        q          = st3_reg.p + (st3_reg.p << 16);
        q          = q ^ (q >> 7);
        q          = q ^ (q >> 3);
        q          = q ^ (q << 6);
        q          = q ^ (q >> 17);
        st4_next   = st3_reg;
        st4_next.p = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= up_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && up_valid)
            st1_reg <= st1_next;
        if (rdy2 && v1_reg)
            st2_reg <= st2_next;
        if (rdy3 && v2_reg)
            st3_reg <= st3_next;
        if (rdy4 && v3_reg)
            st4_reg <= st4_next;
    end

    // A finished hash held back by the next stage must not move or change.
    `APS_ASSERT_NEXT(a_hash_hold, clk, rst_n, v4_reg && !dn_ready,
                     v4_reg && $stable(st4_reg), "Stalled hash result changed")

endmodule

// ===== rtl/aps_sums.sv =====
// ============================================================================
// ASTC partition select sum stage
// Squares and shifts the twelve hash nibbles and forms the four 6-bit
// partition sums from the texel coordinates.
// ============================================================================
module aps_sums (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  aps_pkg::aps_hash_t  hash,
    output logic                dn_valid,
    input  logic                dn_ready,
    output aps_pkg::aps_sums_t  sums
);

    logic               v_reg;
    aps_pkg::aps_sums_t sums_reg;
    aps_pkg::aps_sums_t sums_next;

    assign up_ready = !v_reg || dn_ready;
    assign dn_valid = v_reg;
    assign sums     = sums_reg;

    always_comb
    begin
        logic [31:0] r;
        r = hash.p;
        sums_next.a = aps_pkg::sq_term(r[3:0], hash.sh1, hash.x)
                    + aps_pkg::sq_term(r[7:4], hash.sh2, hash.y)
                    + aps_pkg::sq_term(r[29:26], hash.sh3, hash.z)
                    + r[19:14];
        sums_next.b = aps_pkg::sq_term(r[11:8], hash.sh1, hash.x)
                    + aps_pkg::sq_term(r[15:12], hash.sh2, hash.y)
                    + aps_pkg::sq_term({r[1:0], r[31:30]}, hash.sh3, hash.z)
                    + r[15:10];
        sums_next.c = aps_pkg::sq_term(r[19:16], hash.sh1, hash.x)
                    + aps_pkg::sq_term(r[23:20], hash.sh2, hash.y)
                    + aps_pkg::sq_term(r[21:18], hash.sh3, hash.z)
                    + r[11:6];
        sums_next.d = aps_pkg::sq_term(r[27:24], hash.sh1, hash.x)
                    + aps_pkg::sq_term(r[31:28], hash.sh2, hash.y)
                    + aps_pkg::sq_term(r[25:22], hash.sh3, hash.z)
                    + r[7:2];
        sums_next.cnt_m1 = hash.cnt_m1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            sums_reg <= sums_next;
    end

endmodule

// ===== rtl/aps_select.sv =====
// ============================================================================
// ASTC partition select output stage
// Zeroes the sums of unused partitions, picks the largest with ties going
// to the lower index, and holds the result in the output register.
// ============================================================================
`include "astc_partition_select_defines.svh"

module aps_select (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  aps_pkg::aps_sums_t         sums,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [aps_pkg::IdxW-1:0]   partition_index
);

    logic                       out_valid_reg;
    logic [aps_pkg::IdxW-1:0]   partition_index_reg;
    logic [aps_pkg::IdxW-1:0]   partition_index_next;

    assign up_ready        = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign partition_index = partition_index_reg;

    always_comb
    begin
        logic [aps_pkg::SumW-1:0] a, b, c, d;
        a = sums.a;
        b = (sums.cnt_m1 >= 2'd1) ? sums.b : '0;
        c = (sums.cnt_m1 >= 2'd2) ? sums.c : '0;
        d = (sums.cnt_m1 >= 2'd3) ? sums.d : '0;
        priority if (a >= b && a >= c && a >= d)
            partition_index_next = aps_pkg::Part0;
        else if (b >= c && b >= d)
            partition_index_next = aps_pkg::Part1;
        else if (c >= d)
            partition_index_next = aps_pkg::Part2;
        else
            partition_index_next = aps_pkg::Part3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (up_ready)
            out_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            partition_index_reg <= partition_index_next;
    end

    // The chosen partition never exceeds the number of partitions in use.
    `APS_ASSERT_NEXT(a_index_in_range, clk, rst_n, up_valid && up_ready,
                     partition_index_reg <= $past(sums.cnt_m1),
                     "Partition index beyond partition count")

endmodule

// ===== dv/astc_partition_select_checker.sv =====
// ============================================================================
// ASTC partition select checker
// Watches the configuration port and both handshake channels of the partition
// select block. Every accepted request is turned into the partition index
// that the texel should receive. That index waits in order for the block's
// result, and each result is compared with the oldest waiting index. The
// failure count and the number of results still owed go to the testbench top.
// ============================================================================
module astc_partition_select_checker
    import aps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [SeedW-1:0]   partition_seed,
    input  logic [CountW-1:0]  partition_count,
    input  logic [CoordW-1:0]  texel_x,
    input  logic [CoordW-1:0]  texel_y,
    input  logic [CoordW-1:0]  texel_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [IdxW-1:0]    partition_index,
    output int                 failures,
    output int                 pending
);

    typedef struct {
        logic [IdxW-1:0]   part;
        logic [SeedW-1:0]  seed;
        logic [CountW-1:0] count;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] z;
        logic              dbl;
    } texel_owed_t;

    texel_owed_t owed_parts[$];
    logic        dbl_coords;

    function automatic logic [31:0] scramble_seed(input logic [31:0] v);
        logic [31:0] h;
        h = v;
        h = h ^ (h >> 15);
        h = h - (h << 17);
        h = h + (h << 7);
        h = h + (h << 4);
        h = h ^ (h >> 5);
        h = h + (h << 16);
        h = h ^ (h >> 7);
        h = h ^ (h >> 3);
        h = h ^ (h << 6);
        h = h ^ (h >> 17);
        return h;
    endfunction

    function automatic logic [31:0] squared_nibble(input logic [31:0] v,
                                                   input logic [2:0]  sh);
        logic [31:0] n;
        n = v & 32'hF;
        return (n * n) >> sh;
    endfunction

    function automatic logic [IdxW-1:0] partition_of_texel(
        input logic [SeedW-1:0]  seed,
        input logic [CountW-1:0] count,
        input logic [CoordW-1:0] x,
        input logic [CoordW-1:0] y,
        input logic [CoordW-1:0] z,
        input logic              dbl);
        logic [CountW-1:0] cnt;
        logic [31:0]       sx;
        logic [31:0]       sy;
        logic [31:0]       sz;
        logic [31:0]       key;
        logic [31:0]       r;
        logic [31:0]       wa;
        logic [31:0]       wb;
        logic [31:0]       wc;
        logic [31:0]       wd;
        logic [2:0]        sh1;
        logic [2:0]        sh2;
        logic [2:0]        sh3;
        logic [SumW-1:0]   a;
        logic [SumW-1:0]   b;
        logic [SumW-1:0]   c;
        logic [SumW-1:0]   d;
        cnt = count;
        if (cnt < CountMin) cnt = CountMin;
        if (cnt > CountMax) cnt = CountMax;
        sx = dbl ? {27'd0, x, 1'b0} : {28'd0, x};
        sy = dbl ? {27'd0, y, 1'b0} : {28'd0, y};
        sz = dbl ? {27'd0, z, 1'b0} : {28'd0, z};
        key = {22'd0, seed} + ({29'd0, cnt} - 32'd1) * 32'd1024;
        r = scramble_seed(key);
        if (key[0])
        begin
            sh1 = key[1] ? ShiftLow : ShiftMid;
            sh2 = (cnt == 3'd3) ? ShiftHigh : ShiftMid;
        end
        else
        begin
            sh1 = (cnt == 3'd3) ? ShiftHigh : ShiftMid;
            sh2 = key[1] ? ShiftLow : ShiftMid;
        end
        sh3 = key[4] ? sh1 : sh2;
        wa = squared_nibble(r, sh1) * sx + squared_nibble(r >> 4, sh2) * sy
           + squared_nibble(r >> 26, sh3) * sz + (r >> 14);
        wb = squared_nibble(r >> 8, sh1) * sx + squared_nibble(r >> 12, sh2) * sy
           + squared_nibble((r >> 30) | (r << 2), sh3) * sz + (r >> 10);
        wc = squared_nibble(r >> 16, sh1) * sx + squared_nibble(r >> 20, sh2) * sy
           + squared_nibble(r >> 18, sh3) * sz + (r >> 6);
        wd = squared_nibble(r >> 24, sh1) * sx + squared_nibble(r >> 28, sh2) * sy
           + squared_nibble(r >> 22, sh3) * sz + (r >> 2);
        a = wa[SumW-1:0];
        b = wb[SumW-1:0];
        c = wc[SumW-1:0];
        d = wd[SumW-1:0];
        if (cnt < CountMax) d = '0;
        if (cnt < 3'd3) c = '0;
        if (cnt < 3'd2) b = '0;
        if (a >= b && a >= c && a >= d) return Part0;
        else if (b >= c && b >= d) return Part1;
        else if (c >= d) return Part2;
        return Part3;
    endfunction

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= 100)
            $display("[%0t] partition mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        texel_owed_t head;
        if (!rst_n)
        begin
            dbl_coords = 1'b0;
            owed_parts.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_parts.size() == 0)
                begin
                    report_mismatch($sformatf("index %0d with no request outstanding",
                                              partition_index));
                end
                else
                begin
                    head = owed_parts.pop_front();
                    if (partition_index !== head.part)
                        report_mismatch($sformatf(
                            "seed %0d count %0d texel (%0d,%0d,%0d) doubled %0b: got %0d, want %0d",
                            head.seed, head.count, head.x, head.y, head.z, head.dbl,
                            partition_index, head.part));
                end
            end
            if (in_valid && !in_stall)
            begin
                head.seed  = partition_seed;
                head.count = partition_count;
                head.x     = texel_x;
                head.y     = texel_y;
                head.z     = texel_z;
                head.dbl   = dbl_coords;
                head.part  = partition_of_texel(partition_seed, partition_count,
                                                texel_x, texel_y, texel_z, dbl_coords);
                owed_parts = {owed_parts, head};
            end
            if (cfg_we)
                dbl_coords = cfg_wdata;
            pending = owed_parts.size();
        end
    end

endmodule

// ===== dv/astc_partition_select_tb.sv =====
// ============================================================================
// ASTC partition select testbench
// Drives texel requests into the partition select block under both settings
// of small-block mode: a short directed set covering the field extremes, the
// out-of-range counts and the seed bits that pick the shifts, then random
// phases. Both sides idle at random, and one long hold-off at the output
// fills the pipeline. The checker compares every result and the top gives
// the verdict.
// ============================================================================
module astc_partition_select_tb;
    import aps_pkg::*;

    localparam int QuietLimit    = 2000;
    localparam int HoldOffCycles = 300;
    localparam int RandomPhases  = 6;
    localparam int PhaseRequests = 215;
    localparam int DrainCycles   = 10;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [SeedW-1:0]   partition_seed;
    logic [CountW-1:0]  partition_count;
    logic [CoordW-1:0]  texel_x;
    logic [CoordW-1:0]  texel_y;
    logic [CoordW-1:0]  texel_z;
    logic               out_valid;
    logic               out_stall;
    logic [IdxW-1:0]    partition_index;

    int failures;
    int pending;
    int quiet_cycles = 0;
    bit tx_burst     = 1'b0;
    bit rx_burst     = 1'b0;
    bit hold_off_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    astc_partition_select dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .partition_seed  (partition_seed),
        .partition_count (partition_count),
        .texel_x         (texel_x),
        .texel_y         (texel_y),
        .texel_z         (texel_z),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .partition_index (partition_index)
    );

    astc_partition_select_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .partition_seed  (partition_seed),
        .partition_count (partition_count),
        .texel_x         (texel_x),
        .texel_y         (texel_y),
        .texel_z         (texel_z),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .partition_index (partition_index),
        .failures        (failures),
        .pending         (pending)
    );

    task automatic send_texel(input logic [SeedW-1:0]  seed,
                              input logic [CountW-1:0] cnt,
                              input logic [CoordW-1:0] cx,
                              input logic [CoordW-1:0] cy,
                              input logic [CoordW-1:0] cz);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        partition_seed  <= seed;
        partition_count <= cnt;
        texel_x         <= cx;
        texel_y         <= cy;
        texel_z         <= cz;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic random_request();
        logic [SeedW-1:0]  seed;
        logic [CountW-1:0] cnt;
        int                coord_top;
        seed = SeedW'($urandom_range(0, 1023));
        if ($urandom_range(0, 7) == 0)
            cnt = CountW'($urandom_range(0, 7));
        else
            cnt = CountW'($urandom_range(1, 4));
        coord_top = ($urandom_range(0, 5) == 0) ? 15 : 11;
        send_texel(seed, cnt, CoordW'($urandom_range(0, coord_top)),
                   CoordW'($urandom_range(0, coord_top)),
                   CoordW'($urandom_range(0, coord_top)));
    endtask

    task automatic directed_requests();
        send_texel(10'h000, CountMin, 4'd0,  4'd0,  4'd0);
        send_texel(10'h3FF, CountMax, 4'd15, 4'd15, 4'd15);
        send_texel(10'h001, 3'd0,     4'd11, 4'd11, 4'd11);
        send_texel(10'h002, 3'd5,     4'd15, 4'd0,  4'd7);
        send_texel(10'h003, 3'd6,     4'd0,  4'd15, 4'd3);
        send_texel(10'h010, 3'd7,     4'd7,  4'd7,  4'd15);
        send_texel(10'h011, 3'd2,     4'd11, 4'd0,  4'd0);
        send_texel(10'h012, 3'd3,     4'd0,  4'd11, 4'd0);
        send_texel(10'h013, 3'd3,     4'd5,  4'd9,  4'd0);
        send_texel(10'h2AA, CountMax, 4'd10, 4'd5,  4'd10);
        send_texel(10'h155, 3'd2,     4'd15, 4'd15, 4'd0);
        send_texel(10'h200, CountMin, 4'd15, 4'd15, 4'd15);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_mode(input logic dbl);
        cfg_we    <= 1'b1;
        cfg_wdata <= dbl;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        in_valid        <= 1'b0;
        partition_seed  <= '0;
        partition_count <= CountMin;
        texel_x         <= '0;
        texel_y         <= '0;
        texel_z         <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);
        directed_requests();
        drain_pipeline();
        write_mode(1'b1);
        directed_requests();
        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            drain_pipeline();
            write_mode(phase[0]);
            for (int i = 0; i < PhaseRequests; i++)
            begin
                if (i % 40 == 0)
                    tx_burst = ($urandom_range(0, 3) == 0);
                if (phase == 2 && i == 60)
                begin
                    hold_off_req = 1'b1;
                    tx_burst = 1'b1;
                end
                random_request();
            end
        end
        drain_pipeline();
        if (failures == 0)
            $display("[astc_partition_select] OK");
        else
            $display("[astc_partition_select] ERROR");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        int served;
        served = 0;
        out_stall <= 1'b1;
        @(posedge clk);
        forever
        begin
            if (served % 30 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            wait_cycles = rx_burst ? 0 : $urandom_range(0, 14);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                wait_cycles = HoldOffCycles;
            end
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            served++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("[astc_partition_select] ERROR");
            $finish;
        end
    end

endmodule
